>>> src/pce_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pce_pkg
// Shared types, constants and helper functions for the palette pixel expander.
// ============================================================================
package pce_pkg;

    localparam int NUM_PALETTES_DEF = 8;
    localparam int TABLE_DEPTH      = 256;
    localparam int PIXEL_W          = 32;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 20;

    typedef enum logic [1:0] {
        CMD_RENDER      = 2'd0,
        CMD_SET_TABLE   = 2'd1,
        CMD_SET_PALETTE = 2'd2
    } t_cmd;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PIXEL_DEPTH      = 3'd0,
        REG_COLOR_INDEX_MODE = 3'd1,
        REG_PALETTE_SELECT   = 3'd2,
        REG_COMPONENT_WIDTHS = 3'd3,
        REG_COMPONENT_SHIFTS = 3'd4
    } t_reg_index;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] entry_index;
        logic [7:0] source_byte;
        logic [3:0] palette_number;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       line_end;
    } t_in_word;

    typedef struct packed {
        logic [31:0] pixel_data;
        logic [2:0]  byte_count;
        logic        last_of_line;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  pixel_depth;
        logic        color_index_mode;
        logic [2:0]  palette_select;
        logic [15:0] component_widths;
        logic [19:0] component_shifts;
    } t_cfg;

    function automatic logic [31:0] pack_component(
        input logic [7:0] c,
        input logic [3:0] w,
        input logic [4:0] s
    );
        logic [3:0] wc;
        logic [7:0] v;
        wc = (w > 4'd8) ? 4'd8 : w;
        v  = c >> (4'd8 - wc);
        return {24'b0, v} << s;
    endfunction

    function automatic logic [31:0] depth_mask(input logic [1:0] depth);
        logic [31:0] m;
        case (depth)
            2'd0: begin
                m = 32'h0000_00FF;
            end
            2'd1: begin
                m = 32'h0000_FFFF;
            end
            2'd2: begin
                m = 32'h00FF_FFFF;
            end
            default: begin
                m = 32'hFFFF_FFFF;
            end
        endcase
        return m;
    endfunction

endpackage

>>> src/pce_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// pce_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module pce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pce_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// pce_cfg
// Configuration register bank written through a plain indexed write port.
// ============================================================================
module pce_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pce_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [pce_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output pce_pkg::t_cfg                      o_cfg
);

    pce_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pce_pkg::REG_PIXEL_DEPTH: begin
                    r_cfg.pixel_depth <= i_cfg_data[1:0];
                end
                pce_pkg::REG_COLOR_INDEX_MODE: begin
                    r_cfg.color_index_mode <= i_cfg_data[0];
                end
                pce_pkg::REG_PALETTE_SELECT: begin
                    r_cfg.palette_select <= i_cfg_data[2:0];
                end
                pce_pkg::REG_COMPONENT_WIDTHS: begin
                    r_cfg.component_widths <= i_cfg_data[15:0];
                end
                pce_pkg::REG_COMPONENT_SHIFTS: begin
                    r_cfg.component_shifts <= i_cfg_data[19:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/palette_clut_pixel_expander_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// palette_clut_pixel_expander_unit
// Indexed-color expander with palette stores and a 256-entry lookup table.
// ============================================================================
// A render word is held in the stage-one registers, then in the output register.
// Throughput: one word per cycle unless the sink stalls a waiting result.
// Input ready drops only while a finished result waits and the sink is stalled.
// Reset clears the configuration and the 256 table valid bits, so every
// table entry reads as zero; palette contents are undefined until written.
// ============================================================================
module palette_clut_pixel_expander_unit #(
    parameter int NUM_PALETTES = pce_pkg::NUM_PALETTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pce_pkg::t_in_word               i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pce_pkg::t_out_word              o_out_word,
    input  logic                            i_cfg_we,
    input  logic [pce_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pce_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int TAW = $clog2(pce_pkg::TABLE_DEPTH);
    localparam int PAL_DEPTH = NUM_PALETTES * pce_pkg::TABLE_DEPTH;
    localparam int PAW = $clog2(PAL_DEPTH);

    pce_pkg::t_cfg cfg;

    logic        adv;
    logic        in_acc;
    logic        pal_we;
    logic [PAW-1:0] pal_waddr;
    logic [PAW-1:0] pal_raddr;
    logic [31:0] pal_wdata;
    logic [31:0] pal_q;
    logic [31:0] tbl_q;
    logic        tbl_we;
    logic [31:0] tbl_wdata;
    logic        sel_ok;
    logic        fwd_hit;
    logic [31:0] entry_val;

    logic                        r_s1_valid;
    logic [1:0]                  r_s1_cmd;
    logic [7:0]                  r_s1_entry;
    logic [7:0]                  r_s1_src;
    logic                        r_s1_line_end;
    logic                        r_s1_tvalid;
    logic [pce_pkg::TABLE_DEPTH-1:0] r_tvalid;
    logic                        r_wb_valid;
    logic [TAW-1:0]              r_wb_addr;
    logic [31:0]                 r_wb_data;
    logic                        r_out_valid;
    pce_pkg::t_out_word          r_out_word;
    pce_pkg::t_out_word          n_out_word;

    pce_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign in_acc     = i_in_valid && adv;

    assign pal_we = in_acc && (i_in_word.command == pce_pkg::CMD_SET_PALETTE)
                 && (5'(i_in_word.palette_number) < 5'(NUM_PALETTES));
    assign pal_waddr = PAW'({i_in_word.palette_number, i_in_word.entry_index});
    assign pal_raddr = PAW'({cfg.palette_select, i_in_word.source_byte});
    assign pal_wdata =
        pce_pkg::pack_component(i_in_word.red,   cfg.component_widths[3:0],
                                cfg.component_shifts[4:0])
      | pce_pkg::pack_component(i_in_word.green, cfg.component_widths[7:4],
                                cfg.component_shifts[9:5])
      | pce_pkg::pack_component(i_in_word.blue,  cfg.component_widths[11:8],
                                cfg.component_shifts[14:10])
      | pce_pkg::pack_component(i_in_word.alpha, cfg.component_widths[15:12],
                                cfg.component_shifts[19:15]);

    pce_ram #(
        .WIDTH (32),
        .DEPTH (PAL_DEPTH)
    ) u_palette_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_re    (in_acc),
        .i_raddr (pal_raddr),
        .o_rdata (pal_q)
    );

    assign sel_ok    = 5'(cfg.palette_select) < 5'(NUM_PALETTES);
    assign tbl_we    = adv && r_s1_valid && (r_s1_cmd == pce_pkg::CMD_SET_TABLE) && sel_ok;
    assign tbl_wdata = cfg.color_index_mode ? {24'b0, r_s1_src} : pal_q;

    pce_ram #(
        .WIDTH (32),
        .DEPTH (pce_pkg::TABLE_DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_s1_entry),
        .i_wdata (tbl_wdata),
        .i_re    (in_acc),
        .i_raddr (i_in_word.source_byte),
        .o_rdata (tbl_q)
    );

    // A table write lands at the same edge as the read of the next word,
    // so the most recent write is forwarded.
    assign fwd_hit   = r_wb_valid && (r_wb_addr == r_s1_src);
    assign entry_val = fwd_hit ? r_wb_data : (r_s1_tvalid ? tbl_q : 32'b0);

    always_comb begin
        n_out_word.pixel_data   = entry_val & pce_pkg::depth_mask(cfg.pixel_depth);
        n_out_word.byte_count   = 3'(cfg.pixel_depth) + 3'd1;
        n_out_word.last_of_line = r_s1_line_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_tvalid    <= '0;
        end else begin
            if (adv) begin
                r_s1_valid  <= i_in_valid;
                r_out_valid <= r_s1_valid && (r_s1_cmd == pce_pkg::CMD_RENDER);
            end
            if (tbl_we) begin
                r_wb_valid          <= 1'b1;
                r_tvalid[r_s1_entry] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cmd      <= i_in_word.command;
            r_s1_entry    <= i_in_word.entry_index;
            r_s1_src      <= i_in_word.source_byte;
            r_s1_line_end <= i_in_word.line_end;
            r_s1_tvalid   <= r_tvalid[i_in_word.source_byte];
        end
        if (tbl_we) begin
            r_wb_addr <= r_s1_entry;
            r_wb_data <= tbl_wdata;
        end
        if (adv) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    a_render_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s1_valid && (r_s1_cmd == pce_pkg::CMD_RENDER)) |=> o_out_valid)
        else $error("render word in stage one did not reach the output register");

    a_table_valid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_we |=> r_tvalid[$past(r_s1_entry)])
        else $error("table write did not mark its entry valid");

    a_pixel_masked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.byte_count == 3'd1)) |-> (o_out_word.pixel_data[31:8] == 24'b0))
        else $error("pixel data not masked to the byte count");

    a_palette_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pal_we |-> (in_acc && (5'(i_in_word.palette_number) < 5'(NUM_PALETTES))))
        else $error("palette write outside the configured palettes");

endmodule

>>> tb/pixel_expander_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pixel_expander_checker
// Watches the input, output and register ports of the palette pixel expander.
// It keeps its own copy of the lookup table, the palettes and the registers.
// Each accepted render word adds one expected pixel. Every accepted output word
// is compared field by field with the oldest expected pixel.
// ============================================================================
module pixel_expander_checker #(
    parameter int NUM_PALETTES = pce_pkg::NUM_PALETTES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  pce_pkg::t_in_word               i_in_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  pce_pkg::t_out_word              i_out_word,
    input  logic                            i_cfg_we,
    input  logic [pce_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count
);

    logic [31:0]        clut [pce_pkg::TABLE_DEPTH];
    logic [31:0]        palettes [NUM_PALETTES][pce_pkg::TABLE_DEPTH];
    pce_pkg::t_cfg      regs;
    pce_pkg::t_out_word expected_pixels [$];
    pce_pkg::t_out_word oldest;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    initial begin
        o_pending = 0;
        regs      = '0;
        for (int p = 0; p < NUM_PALETTES; p++) begin
            for (int e = 0; e < pce_pkg::TABLE_DEPTH; e++) begin
                palettes[p][e] = '0;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic logic [31:0] scale_component(input logic [7:0] c, input int k);
        int          width;
        int          shift;
        logic [31:0] v;
        width = regs.component_widths[4*k +: 4];
        shift = regs.component_shifts[5*k +: 5];
        if (width > 8) begin
            width = 8;
        end
        v = {24'b0, c} >> (8 - width);
        return v << shift;
    endfunction

    task automatic predict_pixel(input pce_pkg::t_in_word w);
        pce_pkg::t_out_word px;
        int                 b;
        case (w.command)
            pce_pkg::CMD_RENDER: begin
                px.pixel_data = clut[w.source_byte];
                for (b = 1; b < 4; b++) begin
                    if (b > regs.pixel_depth) begin
                        px.pixel_data[8*b +: 8] = 8'h00;
                    end
                end
                px.byte_count   = {1'b0, regs.pixel_depth} + 3'd1;
                px.last_of_line = w.line_end;
                expected_pixels.push_back(px);
            end
            pce_pkg::CMD_SET_TABLE: begin
                if (regs.palette_select < NUM_PALETTES) begin
                    if (regs.color_index_mode) begin
                        clut[w.entry_index] = {24'b0, w.source_byte};
                    end else begin
                        clut[w.entry_index] = palettes[regs.palette_select][w.source_byte];
                    end
                end
            end
            pce_pkg::CMD_SET_PALETTE: begin
                if (w.palette_number < NUM_PALETTES) begin
                    palettes[w.palette_number][w.entry_index] =
                        scale_component(w.red, 0) | scale_component(w.green, 1) |
                        scale_component(w.blue, 2) | scale_component(w.alpha, 3);
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < pce_pkg::TABLE_DEPTH; e++) begin
                clut[e] = '0;
            end
            regs = '0;
            expected_pixels.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pce_pkg::REG_PIXEL_DEPTH: begin
                        regs.pixel_depth = i_cfg_data[1:0];
                    end
                    pce_pkg::REG_COLOR_INDEX_MODE: begin
                        regs.color_index_mode = i_cfg_data[0];
                    end
                    pce_pkg::REG_PALETTE_SELECT: begin
                        regs.palette_select = i_cfg_data[2:0];
                    end
                    pce_pkg::REG_COMPONENT_WIDTHS: begin
                        regs.component_widths = i_cfg_data[15:0];
                    end
                    pce_pkg::REG_COMPONENT_SHIFTS: begin
                        regs.component_shifts = i_cfg_data[19:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected output word %h", i_out_word));
                end else begin
                    oldest = expected_pixels.pop_front();
                    if (i_out_word.pixel_data !== oldest.pixel_data) begin
                        report_mismatch($sformatf("pixel_data %h, expected %h",
                                                  i_out_word.pixel_data, oldest.pixel_data));
                    end
                    if (i_out_word.byte_count !== oldest.byte_count) begin
                        report_mismatch($sformatf("byte_count %0d, expected %0d",
                                                  i_out_word.byte_count, oldest.byte_count));
                    end
                    if (i_out_word.last_of_line !== oldest.last_of_line) begin
                        report_mismatch($sformatf("last_of_line %b, expected %b",
                                                  i_out_word.last_of_line,
                                                  oldest.last_of_line));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_pixel(i_in_word);
            end
            o_pending <= expected_pixels.size();
        end
    end

endmodule

>>> tb/palette_clut_pixel_expander_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// palette_clut_pixel_expander_unit_test
// Drives the palette pixel expander with a short directed sequence and then
// with random phases of palette loads, table fills and render lines under
// changing register settings, with random stalls on both channels. A checker
// beside the block predicts and compares every pixel word.
// ============================================================================
module palette_clut_pixel_expander_unit_test;

    localparam int         NUM_PAL      = pce_pkg::NUM_PALETTES_DEF;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         RANDOM_WORDS = 1700;
    localparam int         PHASES       = 12;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    pce_pkg::t_in_word               in_word;
    logic                            out_valid;
    logic                            out_ready;
    pce_pkg::t_out_word              out_word;
    logic                            cfg_we;
    logic [pce_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pce_pkg::CFG_DATA_W-1:0]  cfg_data;
    int                              pending;
    int                              fail_count;

    bit            calm;
    pce_pkg::t_cfg cur_cfg;
    int            useful_words;
    bit            pal_written [NUM_PAL][pce_pkg::TABLE_DEPTH];
    logic [7:0]    written_entries [NUM_PAL][$];
    bit            table_used [pce_pkg::TABLE_DEPTH];
    logic [7:0]    table_entries [$];

    always #5 clk = ~clk;

    palette_clut_pixel_expander_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pixel_expander_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : sink
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 7);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic pce_pkg::t_in_word random_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(pce_pkg::t_in_word)-1:0];
    endfunction

    function automatic pce_pkg::t_in_word make_word(input logic [1:0] cmd,
                                                    input logic [7:0] entry,
                                                    input logic [7:0] src,
                                                    input logic [3:0] pal,
                                                    input logic [31:0] rgba,
                                                    input logic le);
        pce_pkg::t_in_word w;
        w.command        = cmd;
        w.entry_index    = entry;
        w.source_byte    = src;
        w.palette_number = pal;
        {w.red, w.green, w.blue, w.alpha} = rgba;
        w.line_end       = le;
        return w;
    endfunction

    function automatic logic [7:0] render_source();
        if (table_entries.size() != 0 && $urandom_range(0, 3) != 0) begin
            return table_entries[$urandom_range(0, table_entries.size() - 1)];
        end
        return 8'($urandom);
    endfunction

    task automatic write_reg(input pce_pkg::t_reg_index idx,
                             input logic [pce_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic write_config(input pce_pkg::t_cfg c);
        write_reg(pce_pkg::REG_PIXEL_DEPTH, 20'(c.pixel_depth));
        write_reg(pce_pkg::REG_COLOR_INDEX_MODE, 20'(c.color_index_mode));
        write_reg(pce_pkg::REG_PALETTE_SELECT, 20'(c.palette_select));
        write_reg(pce_pkg::REG_COMPONENT_WIDTHS, 20'(c.component_widths));
        write_reg(pce_pkg::REG_COMPONENT_SHIFTS, c.component_shifts);
        @(negedge clk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    task automatic send_word(input pce_pkg::t_in_word w);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        if (w.command == pce_pkg::CMD_SET_PALETTE && w.palette_number < NUM_PAL) begin
            if (!pal_written[w.palette_number][w.entry_index]) begin
                pal_written[w.palette_number][w.entry_index] = 1'b1;
                written_entries[w.palette_number].push_back(w.entry_index);
            end
        end
        if (w.command == pce_pkg::CMD_SET_TABLE && !table_used[w.entry_index]) begin
            table_used[w.entry_index] = 1'b1;
            table_entries.push_back(w.entry_index);
        end
        if (w.command != CMD_RESERVED &&
            !(w.command == pce_pkg::CMD_SET_PALETTE && w.palette_number >= NUM_PAL)) begin
            useful_words++;
        end
    endtask

    // Waits until every pixel word has come out, then lets the pipeline settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // In palette mode the source byte must name a palette entry already written.
    task automatic fill_table(input logic [7:0] entry);
        pce_pkg::t_in_word w;
        int                sel;
        sel = cur_cfg.palette_select;
        if (!cur_cfg.color_index_mode && written_entries[sel].size() == 0) begin
            w                = random_word();
            w.command        = pce_pkg::CMD_SET_PALETTE;
            w.palette_number = 4'(sel);
            send_word(w);
        end
        w             = random_word();
        w.command     = pce_pkg::CMD_SET_TABLE;
        w.entry_index = entry;
        if (!cur_cfg.color_index_mode) begin
            w.source_byte = written_entries[sel][$urandom_range(0, written_entries[sel].size() - 1)];
        end
        send_word(w);
    endtask

    task automatic random_burst();
        pce_pkg::t_in_word w;
        logic [7:0]        e;
        logic [7:0]        t;
        int                n;
        int                sel;
        sel = cur_cfg.palette_select;
        case ($urandom_range(0, 9))
            0, 1: begin
                e                = $urandom;
                t                = $urandom;
                w                = random_word();
                w.command        = pce_pkg::CMD_SET_PALETTE;
                w.palette_number = 4'(sel);
                w.entry_index    = e;
                send_word(w);
                w             = random_word();
                w.command     = pce_pkg::CMD_SET_TABLE;
                w.entry_index = t;
                w.source_byte = e;
                send_word(w);
                w             = random_word();
                w.command     = pce_pkg::CMD_RENDER;
                w.source_byte = t;
                send_word(w);
            end
            2, 3, 4: begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    w             = random_word();
                    w.command     = pce_pkg::CMD_RENDER;
                    w.source_byte = render_source();
                    w.line_end    = (i == n - 1);
                    send_word(w);
                end
            end
            5, 6: begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    w         = random_word();
                    w.command = pce_pkg::CMD_SET_PALETTE;
                    if ($urandom_range(0, 1)) begin
                        w.palette_number = 4'(sel);
                    end else begin
                        w.palette_number = 4'($urandom_range(0, NUM_PAL - 1));
                    end
                    send_word(w);
                end
            end
            7: begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    fill_table(8'($urandom));
                end
            end
            8: begin
                w = random_word();
                if (w.command == pce_pkg::CMD_SET_TABLE) begin
                    fill_table(w.entry_index);
                end else begin
                    send_word(w);
                end
            end
            default: begin
                w = random_word();
                if ($urandom_range(0, 1)) begin
                    w.command = CMD_RESERVED;
                end else begin
                    w.command        = pce_pkg::CMD_SET_PALETTE;
                    w.palette_number = 4'($urandom_range(NUM_PAL, 15));
                end
                send_word(w);
            end
        endcase
    endtask

    initial begin : stimulus
        pce_pkg::t_cfg c;
        int            target;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_word      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        cur_cfg      = '0;
        useful_words = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Registers at their reset values: zero widths give all-zero colors.
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h00, 4'h0, 32'h0, 1'b1));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'hFF, 4'h0, 32'h0, 1'b0));
        send_word(make_word(CMD_RESERVED, 8'h33, 8'h44, 4'h5, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(pce_pkg::CMD_SET_PALETTE, 8'h01, 8'h00, 4'h0, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'h07, 8'h01, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h07, 4'h0, 32'h0, 1'b1));
        drain();

        c = '{2'd3, 1'b0, 3'd0, 16'h8888, {5'd24, 5'd16, 5'd8, 5'd0}};
        write_config(c);
        send_word(make_word(pce_pkg::CMD_SET_PALETTE, 8'h00, 8'h00, 4'h0, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_PALETTE, 8'hFF, 8'h00, 4'h0, 32'h1234_5678, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_PALETTE, 8'h00, 8'h00, 4'hF, 32'hAAAA_AAAA, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_PALETTE, 8'h02, 8'h00, 4'h8, 32'h5555_5555, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'h00, 8'h00, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'hFF, 8'hFF, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h00, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'hFF, 4'h0, 32'h0, 1'b1));
        drain();

        c = '{2'd0, 1'b1, 3'd7, 16'hFFFF, 20'hFFFFF};
        write_config(c);
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'h0A, 8'hAB, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'h00, 8'hFF, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h0A, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h00, 4'h0, 32'h0, 1'b1));
        drain();

        // Widths above eight and the widest shifts push bits past the word.
        c = '{2'd2, 1'b0, 3'd7, 16'hFFFF, 20'hFFFFF};
        write_config(c);
        send_word(make_word(pce_pkg::CMD_SET_PALETTE, 8'h03, 8'h00, 4'h7, 32'h8142_2418, 1'b0));
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'h05, 8'h03, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h05, 4'h0, 32'h0, 1'b1));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'hFF, 4'h0, 32'h0, 1'b0));
        drain();

        c = '{2'd1, 1'b0, 3'd0, 16'h5361, 20'h00000};
        write_config(c);
        send_word(make_word(pce_pkg::CMD_SET_TABLE, 8'h01, 8'hFF, 4'h0, 32'h0, 1'b0));
        send_word(make_word(pce_pkg::CMD_RENDER, 8'h00, 8'h01, 4'h0, 32'h0, 1'b1));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            calm               = (ph == PHASES - 1) || ($urandom_range(0, 5) == 0);
            c.pixel_depth      = 2'($urandom_range(0, 3));
            c.color_index_mode = 1'($urandom_range(0, 1));
            c.palette_select   = 3'($urandom_range(0, NUM_PAL - 1));
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 3) == 0) begin
                    c.component_widths[4*k +: 4] = 4'($urandom_range(9, 15));
                end else begin
                    c.component_widths[4*k +: 4] = 4'($urandom_range(0, 8));
                end
            end
            c.component_shifts = 20'($urandom);
            write_config(c);
            target = useful_words + RANDOM_WORDS / PHASES;
            while (useful_words < target) begin
                random_burst();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
